### src/srrw_pkg.sv
// Shared types, field layout and constants of the receive window.
package srrw_pkg;

  localparam int SEQ_W      = 32;
  localparam int CFG_W      = 6;
  localparam int SLOT_OUT_W = 5;
  localparam int TDATA_W    = 104;

  localparam int MAX_WINDOW_DEF = 32;
  localparam int SEQ_BITS_DEF   = 32;

  localparam logic [CFG_W-1:0] WIN_RESET = 6'd32;

  // result kinds, carried on tuser
  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_DLV = 1'b1;

  // output tdata bit positions
  localparam int ACK_SEQ_LO  = 0;
  localparam int SACK_LO     = 32;
  localparam int DLV_SEQ_LO  = 64;
  localparam int DLV_SLOT_LO = 96;
  localparam int DONE_BIT    = 101;
  localparam int PAD_W       = TDATA_W - DONE_BIT - 1;

  typedef struct packed {
    logic start;     // latch header, kick off remainder unit
    logic store;     // mark the slot received
    logic load_ack;  // load acknowledgement into output register
    logic load_dlv;  // load delivery, advance base
  } cmd_t;

  typedef struct packed {
    logic rem_done;
    logic out_free;
    logic ack_last;
    logic dlv_last;
  } sts_t;

endpackage

### src/srrw_rem.sv
// Bit-serial remainder unit: two dividends reduced by the window size in parallel.
module srrw_rem import srrw_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int SEQ_BITS   = SEQ_BITS_DEF,
  localparam int SizeW     = $clog2(MAX_WINDOW + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [SizeW-1:0]    size_i,
  input  logic [SEQ_BITS-1:0] a_i,
  input  logic [SEQ_BITS-1:0] b_i,
  output logic                done_o,
  output logic [SizeW-1:0]    rem_a_o,
  output logic [SizeW-1:0]    rem_b_o
);

  localparam int CntW = $clog2(SEQ_BITS + 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [SEQ_BITS-1:0] a_q, a_d, b_q, b_d;
  logic [SizeW-1:0]    ra_q, ra_d, rb_q, rb_d;
  logic [SizeW:0]      ta, tb, sz;

  // restoring step: shift in next dividend bit, subtract size once if it fits
  assign sz = {1'b0, size_i};
  assign ta = {ra_q, a_q[SEQ_BITS-1]};
  assign tb = {rb_q, b_q[SEQ_BITS-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    ra_d   = ra_q;
    rb_d   = rb_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(SEQ_BITS);
      a_d    = a_i;
      b_d    = b_i;
      ra_d   = '0;
      rb_d   = '0;
    end else if (busy_q) begin
      a_d   = a_q << 1;
      b_d   = b_q << 1;
      ra_d  = (ta >= sz) ? SizeW'(ta - sz) : ta[SizeW-1:0];
      rb_d  = (tb >= sz) ? SizeW'(tb - sz) : tb[SizeW-1:0];
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    b_q  <= b_d;
    ra_q <= ra_d;
    rb_q <= rb_d;
  end

  assign done_o  = done_q;
  assign rem_a_o = ra_q;
  assign rem_b_o = rb_q;

endmodule

### src/srrw_dp.sv
// Datapath: window state, slot bits, selective-ack mask and output register.
module srrw_dp import srrw_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int SEQ_BITS   = SEQ_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic [SEQ_W-1:0]   seq_i,
  input  logic               short_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [TDATA_W-1:0] out_data_o,
  output logic               out_user_o,
  output logic               out_last_o
);

  localparam int SizeW = $clog2(MAX_WINDOW + 1);
  localparam int SumW  = SizeW + 1;
  localparam int SlotW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam logic [SizeW-1:0] MaxSize = SizeW'(MAX_WINDOW);

  logic [CFG_W-1:0]      win_cfg_q;
  logic [SizeW-1:0]      size;
  logic [SEQ_BITS-1:0]   base_q, seq_n, diff, neg;
  logic                  done_q, short_q, in_win_q, near_wrap_q;
  logic [SizeW-1:0]      neg_lo_q;
  logic [SlotW-1:0]      slot_q, bmod_q, nxt;
  logic [MAX_WINDOW-1:0] recv_q, fin_q, recv_after;
  logic [SizeW-1:0]      rem_a, rem_b, bmod_inc;
  logic                  rem_done, fin_now, ack_last, dlv_last;
  logic [SEQ_W-1:0]      mask_w;

  logic                  out_valid_q;
  logic [TDATA_W-1:0]    out_data_q;
  logic                  out_user_q, out_last_q;

  // out-of-range settings clamp to 1..MAX_WINDOW
  always_comb begin
    if (win_cfg_q == '0) begin
      size = SizeW'(1);
    end else if (win_cfg_q > CFG_W'(MAX_WINDOW)) begin
      size = MaxSize;
    end else begin
      size = win_cfg_q[SizeW-1:0];
    end
  end

  assign seq_n = seq_i[SEQ_BITS-1:0];
  assign diff  = seq_n - base_q;
  assign neg   = '0 - base_q;

  srrw_rem #(
    .MAX_WINDOW(MAX_WINDOW),
    .SEQ_BITS  (SEQ_BITS)
  ) u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.start),
    .size_i (size),
    .a_i    (seq_n),
    .b_i    (base_q),
    .done_o (rem_done),
    .rem_a_o(rem_a),
    .rem_b_o(rem_b)
  );

  // one lane per mask bit; near the sequence wrap the slot is the wrapped value itself
  for (genvar j = 1; j < MAX_WINDOW; j++) begin : g_lane
    logic [SumW-1:0]  sum;
    logic [SizeW-1:0] red;
    logic             wrap;
    logic [SlotW-1:0] idx;
    assign sum  = SumW'(bmod_q) + SumW'(j);
    assign red  = (sum >= SumW'(size)) ? SizeW'(sum - SumW'(size)) : sum[SizeW-1:0];
    assign wrap = near_wrap_q && (SizeW'(j) >= neg_lo_q);
    assign idx  = wrap ? SlotW'(SizeW'(j) - neg_lo_q) : red[SlotW-1:0];
    assign mask_w[j-1] = (SizeW'(j) < size) && recv_q[idx];
  end
  for (genvar j = MAX_WINDOW; j <= SEQ_W; j++) begin : g_zero
    assign mask_w[j-1] = 1'b0;
  end

  assign fin_now    = fin_q[bmod_q];
  assign bmod_inc   = SizeW'(bmod_q) + SizeW'(1);
  assign nxt        = (base_q == '1 || bmod_inc == size) ? '0 : bmod_inc[SlotW-1:0];
  assign recv_after = recv_q & ~(MAX_WINDOW'(1) << bmod_q);
  assign ack_last   = done_q || !recv_q[bmod_q];
  assign dlv_last   = fin_now || !recv_after[nxt];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_cfg_q <= WIN_RESET;
      base_q    <= SEQ_BITS'(1);
      done_q    <= 1'b0;
      recv_q    <= '0;
      fin_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        win_cfg_q <= cfg_data_i;
      end
      if (cmd_i.store && !done_q && in_win_q) begin
        recv_q[slot_q] <= 1'b1;
        fin_q[slot_q]  <= short_q;
      end
      if (cmd_i.load_dlv) begin
        recv_q[bmod_q] <= 1'b0;
        fin_q[bmod_q]  <= 1'b0;
        base_q         <= base_q + SEQ_BITS'(1);
        if (fin_now) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  // per-request payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      short_q     <= short_i;
      in_win_q    <= diff < SEQ_BITS'(size);
      near_wrap_q <= (base_q != '0) && (neg < SEQ_BITS'(MAX_WINDOW));
      neg_lo_q    <= neg[SizeW-1:0];
    end
    if (rem_done) begin
      slot_q <= rem_a[SlotW-1:0];
      bmod_q <= rem_b[SlotW-1:0];
    end else if (cmd_i.load_dlv) begin
      bmod_q <= nxt;
    end
  end

  // one-deep output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_ack || cmd_i.load_dlv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_ack) begin
      out_data_q <= {PAD_W'(0), done_q, SLOT_OUT_W'(0), SEQ_W'(0), mask_w,
                     SEQ_W'(base_q)};
      out_user_q <= KIND_ACK;
      out_last_q <= ack_last;
    end else if (cmd_i.load_dlv) begin
      out_data_q <= {PAD_W'(0), fin_now | done_q, SLOT_OUT_W'(bmod_q), SEQ_W'(base_q),
                     SEQ_W'(0), SEQ_W'(0)};
      out_user_q <= KIND_DLV;
      out_last_q <= dlv_last;
    end
  end

  assign sts_o.rem_done = rem_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.ack_last = ack_last;
  assign sts_o.dlv_last = dlv_last;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;
  assign out_last_o  = out_last_q;

endmodule

### src/srrw_ctrl.sv
// Controller: sequences divide, store, acknowledgement and in-order deliveries.
module srrw_ctrl import srrw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StDiv   = 3'd1;
  localparam logic [2:0] StStore = 3'd2;
  localparam logic [2:0] StAck   = 3'd3;
  localparam logic [2:0] StDlv   = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = StDiv;
        end
      end
      StDiv: begin
        if (sts_i.rem_done) begin
          state_d = StStore;
        end
      end
      StStore: begin
        cmd_o.store = 1'b1;
        state_d     = StAck;
      end
      StAck: begin
        if (sts_i.out_free) begin
          cmd_o.load_ack = 1'b1;
          state_d        = sts_i.ack_last ? StIdle : StDlv;
        end
      end
      StDlv: begin
        if (sts_i.out_free) begin
          cmd_o.load_dlv = 1'b1;
          if (sts_i.dlv_last) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == StIdle);

endmodule

### src/selective_repeat_receive_window.sv
// Top level of the selective-repeat receive window with selective-ack mask.
//
//  channel  dir  handshake                 payload
//  s_axis   in   s_axis_tvalid/tready      tdata: seq_num; tlast: short_packet
//  m_axis   out  m_axis_tvalid/tready      tdata: ack_seq..transfer_done;
//                                          tuser: kind; tlast: last
//  cfg      in   cfg_we                    cfg_data: rx_win_len
//
// The acknowledgement is presented after a taken request passes the divide
// and store states, each in-order delivery follows the previous result
// unless m_axis stalls, and s_axis is ready again the cycle after the last
// result is loaded; the bit-serial remainder unit takes one dividend bit a cycle.
// Reset is asynchronous, active low, and needs no clearing pass. A stalled
// m_axis holds the controller behind the one-deep output register.
module selective_repeat_receive_window import srrw_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int SEQ_BITS   = SEQ_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_W-1:0]   cfg_data_i,     // rx_win_len
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [SEQ_W-1:0]   s_axis_tdata_i, // [31:0] seq_num
  input  logic               s_axis_tlast_i, // short_packet
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // [31:0] ack_seq, [63:32] sack_mask, [95:64] deliver_seq,
  // [100:96] deliver_slot, [101] transfer_done, [103:102] zero
  output logic [TDATA_W-1:0] m_axis_tdata_o,
  output logic               m_axis_tuser_o, // kind
  output logic               m_axis_tlast_o  // last
);

  cmd_t cmd;
  sts_t sts;

  srrw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  srrw_dp #(
    .MAX_WINDOW(MAX_WINDOW),
    .SEQ_BITS  (SEQ_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .seq_i      (s_axis_tdata_i),
    .short_i    (s_axis_tlast_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_data_o (m_axis_tdata_o),
    .out_user_o (m_axis_tuser_o),
    .out_last_o (m_axis_tlast_o)
  );

  // busy after taking a request
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while a request is in progress");

  // a result that reports the transfer finished is the last one of its request
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[DONE_BIT] |-> m_axis_tlast_o)
    else $error("result after completion is not last");

  // the mask bit that would alias the base slot is never set
  a_mask_top_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !m_axis_tdata_o[SACK_LO + MAX_WINDOW - 1])
    else $error("sack mask top bit set");

  // only one command at a time from the controller
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.start, cmd.store, cmd.load_ack, cmd.load_dlv}))
    else $error("controller issued overlapping commands");

endmodule

### bench/srrw_window_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the receive window: tracks window state, predicts and checks each result.
module srrw_window_checker import srrw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic               s_axis_tvalid_i,
  input  logic               s_axis_tready_i,
  input  logic [SEQ_W-1:0]   s_axis_tdata_i,   // [31:0] seq_num
  input  logic               s_axis_tlast_i,   // short_packet
  input  logic               m_axis_tvalid_i,
  input  logic               m_axis_tready_i,
  // [31:0] ack_seq, [63:32] sack_mask, [95:64] deliver_seq,
  // [100:96] deliver_slot, [101] transfer_done, [103:102] zero
  input  logic [TDATA_W-1:0] m_axis_tdata_i,
  input  logic               m_axis_tuser_i,   // kind
  input  logic               m_axis_tlast_i,   // last
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output logic [SEQ_W-1:0]   base_o
);

  typedef struct packed {
    logic                  kind;
    logic [SEQ_W-1:0]      ack_seq;
    logic [SEQ_W-1:0]      sack;
    logic [SEQ_W-1:0]      dlv_seq;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  done;
    logic                  last;
  } reply_t;

  reply_t           ack_dlv_q[$];
  logic [CFG_W-1:0] win_reg;
  logic [SEQ_W-1:0] base;
  logic             got [MAX_WINDOW_DEF];
  logic             fin [MAX_WINDOW_DEF];
  logic             finished;
  int unsigned      fails = 0;

  function automatic int unsigned span_of(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_WINDOW_DEF) return MAX_WINDOW_DEF;
    return v;
  endfunction

  // acknowledgement first, then in-order releases until a gap or the final packet
  task automatic admit_header(input logic [SEQ_W-1:0] seq, input logic is_short);
    int unsigned      span;
    int unsigned      slot;
    logic [SEQ_W-1:0] probe;
    logic [SEQ_W-1:0] sack;
    reply_t           held;
    span = span_of(win_reg);
    sack = '0;
    probe = seq - base;
    if (!finished && probe < span) begin
      slot = seq % span;
      got[slot] = 1'b1;
      fin[slot] = is_short;
    end
    for (int i = 0; i + 1 < span; i++) begin
      probe = base + SEQ_W'(i + 1);
      if (got[probe % span]) sack[i] = 1'b1;
    end
    held = '0;
    held.kind = KIND_ACK;
    held.ack_seq = base;
    held.sack = sack;
    held.done = finished;
    if (!finished) begin
      for (int i = 0; i < span; i++) begin
        slot = base % span;
        if (!got[slot]) break;
        ack_dlv_q.push_back(held);
        got[slot] = 1'b0;
        if (fin[slot]) finished = 1'b1;
        fin[slot] = 1'b0;
        held = '0;
        held.kind = KIND_DLV;
        held.dlv_seq = base;
        held.slot = SLOT_OUT_W'(slot);
        held.done = finished;
        base = base + 1'b1;
        if (finished) break;
      end
    end
    held.last = 1'b1;
    ack_dlv_q.push_back(held);
  endtask

  task automatic check_field(input string what, input logic [SEQ_W-1:0] want,
                             input logic [SEQ_W-1:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, seen);
      fails++;
    end
  endtask

  task automatic check_reply();
    reply_t want;
    if (ack_dlv_q.size() == 0) begin
      $display("%0t: unexpected result, kind %b tdata %h last %b", $time,
               m_axis_tuser_i, m_axis_tdata_i, m_axis_tlast_i);
      fails++;
      return;
    end
    want = ack_dlv_q.pop_front();
    check_field("kind", want.kind, m_axis_tuser_i);
    check_field("ack_seq", want.ack_seq, m_axis_tdata_i[ACK_SEQ_LO +: SEQ_W]);
    check_field("sack_mask", want.sack, m_axis_tdata_i[SACK_LO +: SEQ_W]);
    check_field("deliver_seq", want.dlv_seq, m_axis_tdata_i[DLV_SEQ_LO +: SEQ_W]);
    check_field("deliver_slot", want.slot, m_axis_tdata_i[DLV_SLOT_LO +: SLOT_OUT_W]);
    check_field("transfer_done", want.done, m_axis_tdata_i[DONE_BIT]);
    check_field("tdata padding", '0, m_axis_tdata_i[TDATA_W-1 -: PAD_W]);
    check_field("last", want.last, m_axis_tlast_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_dlv_q.delete();
      win_reg = WIN_RESET;
      base = 1;
      finished = 1'b0;
      for (int k = 0; k < MAX_WINDOW_DEF; k++) begin
        got[k] = 1'b0;
        fin[k] = 1'b0;
      end
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) check_reply();
      if (cfg_we_i) win_reg = cfg_data_i;
      if (s_axis_tvalid_i && s_axis_tready_i) admit_header(s_axis_tdata_i, s_axis_tlast_i);
    end
    fail_count_o <= fails;
    pending_o <= ack_dlv_q.size();
    base_o <= base;
  end

endmodule

### bench/selective_repeat_receive_window_tb.sv
`timescale 1ns / 1ps
// Top of the receive window bench: clock, reset, packet headers, window writes and verdict.
module selective_repeat_receive_window_tb;
  import srrw_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               s_valid = 1'b0;
  logic               s_ready;
  logic [SEQ_W-1:0]   s_data = '0;   // [31:0] seq_num
  logic               s_last = 1'b0; // short_packet
  logic               m_valid;
  logic               m_ready = 1'b0;
  logic [TDATA_W-1:0] m_data;        // ack_seq, sack_mask, deliver_seq, slot, done
  logic               m_kind;        // kind
  logic               m_last;        // last
  int unsigned        fail_count;
  int unsigned        pending;
  logic [SEQ_W-1:0]   rx_base;
  logic               calm = 1'b0;
  int unsigned        win_span = MAX_WINDOW_DEF;
  int unsigned        headers_sent = 0;

  selective_repeat_receive_window u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_kind),
    .m_axis_tlast_o  (m_last)
  );

  srrw_window_checker u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .m_axis_tuser_i  (m_kind),
    .m_axis_tlast_i  (m_last),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .base_o          (rx_base)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("selective_repeat_receive_window_tb NOT OK");
    $finish;
  end

  // result side back-pressure: bursts of stalls, with quiet stretches
  initial begin
    int unsigned stall_left;
    logic        quiet;
    stall_left = 0;
    quiet = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(99, 0) == 0) quiet = !quiet;
      if (calm || quiet) begin
        m_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if ($urandom_range(9, 0) == 0) begin
        stall_left = $urandom_range(17, 1) - 1;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // called and returns at a falling edge
  task automatic send_header(input logic [SEQ_W-1:0] seq, input logic is_short);
    int unsigned gap;
    if (!calm && $urandom_range(3, 0) == 0) begin
      gap = $urandom_range(17, 1);
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= seq;
    s_last <= is_short;
    do @(posedge clk_i); while (!s_ready);
    headers_sent++;
    @(negedge clk_i);
  endtask

  task automatic settle();
    s_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_window(input logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    win_span = (value == '0) ? 1 : ((value > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : value);
  endtask

  // stray headers: below, above or inside the window; short only where it cannot be stored
  task automatic send_noise();
    logic [SEQ_W-1:0] seq;
    logic [SEQ_W-1:0] off;
    logic             is_short;
    is_short = 1'b0;
    case ($urandom_range(3, 0))
      0: seq = $urandom();
      1: seq = rx_base - SEQ_W'($urandom_range(8, 1));
      2: seq = rx_base + SEQ_W'(win_span) + SEQ_W'($urandom_range(3, 0));
      default: seq = rx_base + SEQ_W'($urandom_range(win_span - 1, 0));
    endcase
    off = seq - rx_base;
    if (off >= win_span) is_short = $urandom_range(1, 0);
    send_header(seq, is_short);
  endtask

  // one window's worth of headers in shuffled order
  task automatic run_block(input logic final_block);
    logic [SEQ_W-1:0] order [MAX_WINDOW_DEF];
    logic [SEQ_W-1:0] start;
    logic [SEQ_W-1:0] tmp;
    int               j;
    start = rx_base;
    for (int k = 0; k < win_span; k++) order[k] = start + SEQ_W'(k);
    for (int k = int'(win_span) - 1; k > 0; k--) begin
      j = $urandom_range(k, 0);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    // base last: the whole window drains on one request
    if ($urandom_range(2, 0) == 0) begin
      for (int k = 0; k < win_span; k++) begin
        if (order[k] == start) begin
          order[k] = order[win_span-1];
          order[win_span-1] = start;
        end
      end
    end
    for (int k = 0; k < win_span; k++) begin
      if (!final_block && $urandom_range(4, 0) == 0) send_noise();
      send_header(order[k], final_block && order[k] == start + SEQ_W'(win_span - 1));
    end
  endtask

  initial begin
    logic [CFG_W-1:0] phase_sizes [7];
    int unsigned      mark;
    phase_sizes = '{6'd7, 6'd1, 6'd32, 6'd5, 6'd16, 6'd3, 6'd31};
    repeat (5) @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // reset window of 32 from base 1: edges, wrap below base, final flag rewritten
    send_header(32'd0, 1'b1);
    send_header(32'hFFFF_FFFF, 1'b1);
    send_header(32'd33, 1'b0);
    send_header(32'd32, 1'b0);
    send_header(32'd3, 1'b1);
    send_header(32'd3, 1'b0);
    send_header(32'd2, 1'b0);
    send_header(32'd1, 1'b0);
    send_header(32'd32, 1'b0);
    send_header(32'd5, 1'b0);

    // zero acts as one; stale slots read under the new size
    settle();
    set_window(6'd0);
    send_header(32'd9, 1'b0);
    send_header(32'd5, 1'b0);
    send_header(32'd7, 1'b0);

    // above the maximum acts as the maximum
    settle();
    set_window(6'd63);
    send_header(rx_base + 32'd31, 1'b0);
    send_header(rx_base + 32'd32, 1'b1);
    send_header(rx_base, 1'b0);

    foreach (phase_sizes[p]) begin
      settle();
      set_window(phase_sizes[p]);
      mark = headers_sent;
      while (headers_sent - mark < 10) run_block(1'b0);
    end

    // closing transfer without idling, then headers after completion
    settle();
    calm = 1'b1;
    set_window(6'd4);
    run_block(1'b1);
    repeat (6) send_header(rx_base + SEQ_W'($urandom_range(3, 0)), 1'($urandom_range(1, 0)));
    repeat (3) send_noise();

    s_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("selective_repeat_receive_window_tb OK");
    end else begin
      $display("selective_repeat_receive_window_tb NOT OK");
    end
    $finish;
  end

endmodule
